// ----- rtl/core/mpow_pkg.sv -----
// ----------------------------------------------------------------------------
// mpow_pkg
// Shared types and constants for the modular power of two or three unit.
// ----------------------------------------------------------------------------
package mpow_pkg;

  // Width of the exponent, modulus and result fields on the ports
  localparam int DATA_W = 64;

  // Default width of the arithmetic datapath
  localparam int DEF_WIDTH = 64;

  // Opcodes
  localparam logic OP_BASE_TWO   = 1'b0;
  localparam logic OP_BASE_THREE = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SQR  = 5'b01000,
    ST_FIN  = 5'b10000
  } mpow_state_t;

endpackage

// ----- rtl/core/modular_power_of_two_or_three_unit.sv -----
// ----------------------------------------------------------------------------
// modular_power_of_two_or_three_unit
// Computes 2^exponent or 3^exponent mod modulus by square and multiply.
// ----------------------------------------------------------------------------
// One request at a time: base^exponent mod modulus, with base 2 (opcode 0) or
// base 3 (opcode 1), over the low WIDTH bits of exponent and modulus. The
// result is fully reduced; a modulus of 1 gives 0, a zero modulus returns 0
// with out_bad_modulus set. All products are formed by one shared
// double-and-add modular unit, one multiplier bit per cycle. The exponent
// is scanned LSB first; each bit takes a sequencing step plus, if set, one
// multiply, and every bit below the highest set bit also takes one square.
// Scanning stops after the highest set bit. A zero exponent ends after the
// sequencing step alone, and a zero modulus goes straight to the finish
// state. The unit waits in the finish state while an earlier result still
// stalls at the output. in_ready is high only while idle; a finished result
// waits in the output register while the next request is taken.
module modular_power_of_two_or_three_unit #(
  parameter int WIDTH = mpow_pkg::DEF_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [mpow_pkg::DATA_W-1:0] in_exponent,
  input  logic [mpow_pkg::DATA_W-1:0] in_modulus,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mpow_pkg::DATA_W-1:0] out_result,
  output logic                        out_bad_modulus
);
  import mpow_pkg::*;

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  mpow_state_t       state_r, state_nxt;
  logic [WIDTH-1:0]  m_r, m_nxt;
  logic [WIDTH-1:0]  e_r, e_nxt;
  logic [WIDTH-1:0]  acc_r, acc_nxt;
  logic [WIDTH-1:0]  sq_r, sq_nxt;
  logic [WIDTH-1:0]  prod_r, prod_nxt;
  logic [WIDTH-1:0]  mb_r, mb_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              bad_r, bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0]  out_result_r, out_result_nxt;
  logic              out_bad_r, out_bad_nxt;

  // input decode
  logic [WIDTH-1:0]  in_m;
  logic [WIDTH-1:0]  in_e;
  logic              m_is_zero, m_is_one, m_is_two, m_is_three;
  logic [WIDTH-1:0]  base_red;

  // shared modular double-and-add unit
  logic [WIDTH:0]    dbl_sum;
  logic [WIDTH-1:0]  dbl_red;
  logic [WIDTH:0]    add_sum;
  logic [WIDTH-1:0]  add_red;
  logic [WIDTH-1:0]  unit_out;
  logic              mul_last;

  assign in_m       = in_modulus[WIDTH-1:0];
  assign in_e       = in_exponent[WIDTH-1:0];
  assign m_is_zero  = (in_m == '0);
  assign m_is_one   = (in_m == WIDTH'(1));
  assign m_is_two   = (in_m == WIDTH'(2));
  assign m_is_three = (in_m == WIDTH'(3));

  // base mod m for the small moduli that do not exceed the base
  always_comb begin
    base_red = '0;
    if (in_opcode == OP_BASE_THREE) begin
      if (m_is_two) begin
        base_red = WIDTH'(1);
      end else if (!m_is_one && !m_is_three) begin
        base_red = WIDTH'(3);
      end
    end else begin
      if (!m_is_one && !m_is_two) begin
        base_red = WIDTH'(2);
      end
    end
  end

  // prod <- 2*prod mod m, then + sq mod m if the multiplier bit is set
  assign dbl_sum  = {prod_r, 1'b0};
  assign dbl_red  = (dbl_sum >= {1'b0, m_r}) ? WIDTH'(dbl_sum - {1'b0, m_r})
                                             : dbl_sum[WIDTH-1:0];
  assign add_sum  = {1'b0, dbl_red} + {1'b0, sq_r};
  assign add_red  = (add_sum >= {1'b0, m_r}) ? WIDTH'(add_sum - {1'b0, m_r})
                                             : add_sum[WIDTH-1:0];
  assign unit_out = mb_r[WIDTH-1] ? add_red : dbl_red;
  assign mul_last = (cnt_r == CNT_LAST);

  always_comb begin
    state_nxt      = state_r;
    m_nxt          = m_r;
    e_nxt          = e_r;
    acc_nxt        = acc_r;
    sq_nxt         = sq_r;
    prod_nxt       = prod_r;
    mb_nxt         = mb_r;
    cnt_nxt        = cnt_r;
    bad_nxt        = bad_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_bad_nxt    = out_bad_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          m_nxt   = in_m;
          e_nxt   = in_e;
          sq_nxt  = base_red;
          acc_nxt = (m_is_zero || m_is_one) ? '0 : WIDTH'(1);
          bad_nxt = m_is_zero;
          if (m_is_zero) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        prod_nxt = '0;
        cnt_nxt  = '0;
        if (e_r == '0) begin
          state_nxt = ST_FIN;
        end else if (e_r[0]) begin
          mb_nxt    = acc_r;
          state_nxt = ST_MUL;
        end else begin
          mb_nxt    = sq_r;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        prod_nxt = unit_out;
        mb_nxt   = {mb_r[WIDTH-2:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (mul_last) begin
          acc_nxt  = unit_out;
          prod_nxt = '0;
          cnt_nxt  = '0;
          mb_nxt   = sq_r;
          // no square needed after the top exponent bit
          if (e_r[WIDTH-1:1] == '0) begin
            e_nxt     = '0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        prod_nxt = unit_out;
        mb_nxt   = {mb_r[WIDTH-2:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (mul_last) begin
          sq_nxt    = unit_out;
          e_nxt     = {1'b0, e_r[WIDTH-1:1]};
          state_nxt = ST_STEP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          out_bad_nxt    = bad_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r          <= m_nxt;
    e_r          <= e_nxt;
    acc_r        <= acc_nxt;
    sq_r         <= sq_nxt;
    prod_r       <= prod_nxt;
    mb_r         <= mb_nxt;
    cnt_r        <= cnt_nxt;
    bad_r        <= bad_nxt;
    out_result_r <= out_result_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result      = DATA_W'(out_result_r);
  assign out_bad_modulus = out_bad_r;

endmodule
